// ----- rtl/yuv_to_rgb565_pair_macros.svh -----
// ---------------------------------------------------------------------------
// yuv_to_rgb565_pair assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef YUV_TO_RGB565_PAIR_MACROS_SVH
`define YUV_TO_RGB565_PAIR_MACROS_SVH

// Same-cycle implication.
`define Y2RGB_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define Y2RGB_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/y2rgb_pkg.sv -----
// ---------------------------------------------------------------------------
// y2rgb_pkg
// Coefficients, shared types and the channel clamp of the YUV to RGB565 block.
// ---------------------------------------------------------------------------
package y2rgb_pkg;

    // Fixed-point coefficients, scaled by 256.
    localparam logic signed [17:0] COEF_Y  = 18'sd298;
    localparam logic signed [17:0] COEF_UB = 18'sd517;
    localparam logic signed [16:0] COEF_UG = 17'sd100;
    localparam logic signed [16:0] COEF_VG = 17'sd208;
    localparam logic signed [16:0] COEF_VR = 17'sd409;

    // Video-range luma offset.
    localparam logic signed [8:0] LUMA_OFS = 9'sd16;

    // Chroma contributions shared by both lanes.
    typedef struct packed {
        logic signed [17:0] blue;   // 517 * U
        logic signed [16:0] green;  // 100 * U + 208 * V, subtracted
        logic signed [16:0] red;    // 409 * V
    } chroma_terms_t;

    // Divide a channel sum by 256 with truncation toward zero, then clamp
    // to 0..255. Any negative sum ends at zero either way.
    function automatic logic [7:0] clamp_channel(input logic signed [19:0] sum);
        logic [7:0] res;
        if (sum[19])
        begin
            res = 8'd0;
        end
        else if (sum[18:16] != 3'd0)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = sum[15:8];
        end
        return res;
    endfunction

endpackage

// ----- rtl/y2rgb_lane.sv -----
// ---------------------------------------------------------------------------
// y2rgb_lane
// One pixel lane: adds the luma term to the shared chroma terms, clamps each
// channel and packs the result as RGB565.
// ---------------------------------------------------------------------------
module y2rgb_lane
    import y2rgb_pkg::*;
(
    input  logic signed [17:0] luma_term,
    input  chroma_terms_t      terms,
    output logic [15:0]        pixel
);

    logic signed [19:0] luma_ext;
    logic signed [19:0] sum_blue;
    logic signed [19:0] sum_green;
    logic signed [19:0] sum_red;
    logic [7:0]         chan_b;
    logic [7:0]         chan_g;
    logic [7:0]         chan_r;

    // Channel sums, sign-extended to a common width.
    assign luma_ext  = $signed({{2{luma_term[17]}}, luma_term});
    assign sum_blue  = luma_ext + $signed({{2{terms.blue[17]}}, terms.blue});
    assign sum_green = luma_ext - $signed({{3{terms.green[16]}}, terms.green});
    assign sum_red   = luma_ext + $signed({{3{terms.red[16]}}, terms.red});

    // Scale, clamp and pack R[15:11] G[10:5] B[4:0].
    assign chan_b = clamp_channel(sum_blue);
    assign chan_g = clamp_channel(sum_green);
    assign chan_r = clamp_channel(sum_red);
    assign pixel  = {chan_r[7:3], chan_g[7:2], chan_b[7:3]};

endmodule

// ----- rtl/yuv_to_rgb565_pair.sv -----
// ---------------------------------------------------------------------------
// yuv_to_rgb565_pair
// Converts a pair of video-range YUV pixels sharing one chroma pair to RGB565.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (pix_valid / pix_ready) carries one request: two luma
//   samples and the shared U and V samples. The output channel
//   (pair_valid / pair_ready) returns packed_pair, first pixel in bits 15:0
//   and second pixel in bits 31:16, one result per request, in order.
//   The datapath has two register stages: the first holds the luma and
//   chroma products, the second is the output register fed by two lanes
//   that form the sums, clamp and pack. An accepted request passes through
//   the product stage and then the output register, where it raises
//   pair_valid. Throughput is one pixel pair per cycle, set by the pipeline
//   advancing every cycle that the output is taken.
//   When the receiver stalls, the output register holds its result, the
//   product stage fills, and then pix_ready drops until pair_ready returns.
//   Reset empties both stages; no result is pending afterward.
// ---------------------------------------------------------------------------
`include "yuv_to_rgb565_pair_macros.svh"

module yuv_to_rgb565_pair
    import y2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    output logic        pix_ready,
    input  logic [7:0]  luma_first,
    input  logic [7:0]  luma_second,
    input  logic [7:0]  chroma_blue,
    input  logic [7:0]  chroma_red,
    output logic        pair_valid,
    input  logic        pair_ready,
    output logic [31:0] packed_pair
);

    logic signed [8:0]  ys_first;
    logic signed [8:0]  ys_second;
    logic signed [7:0]  us;
    logic signed [7:0]  vs;
    logic signed [17:0] luma_first_next;
    logic signed [17:0] luma_second_next;
    chroma_terms_t      terms_next;

    logic signed [17:0] luma_first_reg;
    logic signed [17:0] luma_second_reg;
    chroma_terms_t      terms_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;

    logic [15:0]        pixel_first;
    logic [15:0]        pixel_second;
    logic [31:0]        packed_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               out_adv;
    logic               s1_load;

    // Remove offsets; offset-binary chroma becomes signed by flipping its MSB.
    assign ys_first  = $signed({1'b0, luma_first}) - LUMA_OFS;
    assign ys_second = $signed({1'b0, luma_second}) - LUMA_OFS;
    assign us        = $signed({~chroma_blue[7], chroma_blue[6:0]});
    assign vs        = $signed({~chroma_red[7], chroma_red[6:0]});

    // Stage one products.
    assign luma_first_next  = $signed({{9{ys_first[8]}}, ys_first}) * COEF_Y;
    assign luma_second_next = $signed({{9{ys_second[8]}}, ys_second}) * COEF_Y;
    assign terms_next.blue  = $signed({{10{us[7]}}, us}) * COEF_UB;
    assign terms_next.green = $signed({{9{us[7]}}, us}) * COEF_UG
                            + $signed({{9{vs[7]}}, vs}) * COEF_VG;
    assign terms_next.red   = $signed({{9{vs[7]}}, vs}) * COEF_VR;

    // Pipeline flow control: a stage loads when it is empty or drains.
    assign out_adv   = !out_valid_reg || pair_ready;
    assign s1_load   = !s1_valid_reg || out_adv;
    assign pix_ready = s1_load;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = pix_valid;
        end
        if (out_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Product stage payload.
    always_ff @(posedge clk)
    begin
        if (pix_valid && s1_load)
        begin
            luma_first_reg  <= luma_first_next;
            luma_second_reg <= luma_second_next;
            terms_reg       <= terms_next;
        end
    end

    // Two conversion lanes share the chroma terms.
    y2rgb_lane u_lane_first
    (
        .luma_term (luma_first_reg),
        .terms     (terms_reg),
        .pixel     (pixel_first)
    );

    y2rgb_lane u_lane_second
    (
        .luma_term (luma_second_reg),
        .terms     (terms_reg),
        .pixel     (pixel_second)
    );

    // Merge the lanes into the output register.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_adv)
        begin
            packed_reg <= {pixel_second, pixel_first};
        end
    end

    assign pair_valid  = out_valid_reg;
    assign packed_pair = packed_reg;

    // Assertions.
    `Y2RGB_ASSERT_NOW(a_stall_blocks_input,
        s1_valid_reg && out_valid_reg && !pair_ready, !pix_ready,
        "input accepted while both stages are full and stalled")
    `Y2RGB_ASSERT_NOW(a_empty_stage_ready, !s1_valid_reg, pix_ready,
        "empty product stage refuses a request")
    `Y2RGB_ASSERT_NEXT(a_accept_fills_s1, pix_valid && pix_ready, s1_valid_reg,
        "accepted request lost before the product stage")
    `Y2RGB_ASSERT_NEXT(a_s1_reaches_output,
        s1_valid_reg && (!out_valid_reg || pair_ready), out_valid_reg,
        "product stage drained without filling the output")

endmodule
